### hw/rtl/epr_pkg.sv
// Shared types and constants of the extent path resolver.
package epr_pkg;

  localparam int CAP_W   = 48;
  localparam int COUNT_W = 32;
  localparam int IDX_W   = 31;
  localparam int ST_W    = 2;

  localparam logic [ST_W-1:0] ST_REGULAR  = 2'd0;
  localparam logic [ST_W-1:0] ST_ROOT     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

  localparam logic [1:0] REG_CAPACITY    = 2'd0;
  localparam logic [1:0] REG_EXTENT_SIZE = 2'd1;
  localparam logic [1:0] REG_EXTENT_CNT  = 2'd2;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [IDX_W-1:0] INDEX_MAX = 31'h7FFF_FFFF;
  localparam logic [3:0]       DEC_BASE  = 4'd10;

  // Finished path handed from the parser to the window pipeline.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] idx;
  } path_item_t;

  // Device geometry as held in the configuration registers.
  typedef struct packed {
    logic [CAP_W-1:0]   capacity;
    logic [CAP_W-1:0]   extent_bytes;
    logic [COUNT_W-1:0] extent_count;
  } geom_t;

endpackage

### hw/rtl/epr_parse.sv
// Path byte parser: accumulates the decimal index and emits one item per path.
module epr_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ch,
  input  logic                empty_path,
  input  logic                last,
  output logic                item_valid,
  input  logic                item_ready,
  output epr_pkg::path_item_t item
);
  import epr_pkg::*;

  logic [IDX_W-1:0] index_accum, index_accum_next;
  logic             at_start, slash_only, digit_seen, path_bad;
  logic             slash_only_next, digit_seen_next, path_bad_next;
  logic             is_digit, lead_slash, accept, finish;
  logic [IDX_W+3:0] mac;
  path_item_t       item_next;

  assign in_ready = !item_valid || item_ready;
  assign accept   = in_valid && in_ready;
  assign finish   = empty_path || last;

  assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign lead_slash = at_start && (ch == CH_SLASH);
  assign mac = {4'd0, index_accum} * (IDX_W+4)'(DEC_BASE) + (IDX_W+4)'(ch - CH_ZERO);

  always_comb begin
    index_accum_next = index_accum;
    slash_only_next  = slash_only;
    digit_seen_next  = digit_seen;
    path_bad_next    = path_bad;
    if (lead_slash) begin
      slash_only_next = 1'b1;
    end else if (is_digit) begin
      if (!path_bad) begin
        digit_seen_next = 1'b1;
        if (mac > {4'd0, INDEX_MAX}) begin
          path_bad_next = 1'b1;
        end else begin
          index_accum_next = mac[IDX_W-1:0];
        end
      end
    end else begin
      path_bad_next = 1'b1;
    end
  end

  always_comb begin
    item_next.idx = '0;
    if (empty_path) begin
      item_next.status = ST_ROOT;
    end else if (path_bad_next) begin
      item_next.status = ST_NOTFOUND;
    end else if (!digit_seen_next) begin
      item_next.status = slash_only_next ? ST_ROOT : ST_NOTFOUND;
    end else begin
      item_next.status = ST_REGULAR;
      item_next.idx    = index_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_accum <= '0;
      at_start    <= 1'b1;
      slash_only  <= 1'b0;
      digit_seen  <= 1'b0;
      path_bad    <= 1'b0;
    end else if (accept) begin
      if (finish) begin
        index_accum <= '0;
        at_start    <= 1'b1;
        slash_only  <= 1'b0;
        digit_seen  <= 1'b0;
        path_bad    <= 1'b0;
      end else begin
        index_accum <= index_accum_next;
        at_start    <= 1'b0;
        slash_only  <= slash_only_next;
        digit_seen  <= digit_seen_next;
        path_bad    <= path_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept && finish) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && finish) begin
      item <= item_next;
    end
  end

endmodule

### hw/rtl/epr_window.sv
// Window pipeline: range check, split base multiply, saturation and tail length.
module epr_window (
  input  logic                      clk,
  input  logic                      rst,
  input  epr_pkg::geom_t            geom,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  epr_pkg::path_item_t       item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [epr_pkg::ST_W-1:0]  status,
  output logic [epr_pkg::IDX_W-1:0] extent_index,
  output logic [epr_pkg::CAP_W-1:0] byte_base,
  output logic [epr_pkg::CAP_W-1:0] byte_length
);
  import epr_pkg::*;

  localparam int HALF_W = CAP_W / 2;
  localparam int PP_W   = IDX_W + HALF_W;
  localparam int PROD_W = IDX_W + CAP_W;

  // stage A: range check and partial products
  logic              va, ra, tail_a;
  logic [ST_W-1:0]   st_a;
  logic [IDX_W-1:0]  idx_a;
  logic [PP_W-1:0]   pp_lo, pp_hi;
  // stage B: base assembled and saturated
  logic              vb, rb, tail_b;
  logic [ST_W-1:0]   st_b;
  logic [IDX_W-1:0]  idx_b;
  logic [CAP_W-1:0]  base_b;
  logic              ro;

  logic              in_range, is_tail;
  logic [PROD_W-1:0] prod;
  logic [CAP_W-1:0]  len_next;

  assign ro         = !out_valid || out_ready;
  assign rb         = !vb || ro;
  assign ra         = !va || rb;
  assign item_ready = ra;

  assign in_range = {1'b0, item.idx} < geom.extent_count;
  assign is_tail  = {1'b0, item.idx} == (geom.extent_count - COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && item_valid) begin
      if (item.status == ST_REGULAR && !in_range) begin
        st_a  <= ST_NOTFOUND;
        idx_a <= '0;
      end else begin
        st_a  <= item.status;
        idx_a <= item.idx;
      end
      tail_a <= is_tail;
      pp_lo  <= {{HALF_W{1'b0}}, item.idx} * {{IDX_W{1'b0}}, geom.extent_bytes[HALF_W-1:0]};
      pp_hi  <= {{HALF_W{1'b0}}, item.idx} * {{IDX_W{1'b0}}, geom.extent_bytes[CAP_W-1:HALF_W]};
    end
  end

  assign prod = {pp_hi, {HALF_W{1'b0}}} + {{(PROD_W-PP_W){1'b0}}, pp_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rb && va) begin
      st_b   <= st_a;
      idx_b  <= idx_a;
      tail_b <= tail_a;
      base_b <= (|prod[PROD_W-1:CAP_W]) ? {CAP_W{1'b1}} : prod[CAP_W-1:0];
    end
  end

  always_comb begin
    if (!tail_b) begin
      len_next = geom.extent_bytes;
    end else if (geom.capacity > base_b) begin
      len_next = geom.capacity - base_b;
    end else begin
      len_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ro) begin
      out_valid <= vb;
    end
  end

  // drop the window fields for anything but a regular extent
  always_ff @(posedge clk) begin
    if (ro && vb) begin
      status <= st_b;
      if (st_b == ST_REGULAR) begin
        extent_index <= idx_b;
        byte_base    <= base_b;
        byte_length  <= len_next;
      end else begin
        extent_index <= '0;
        byte_base    <= '0;
        byte_length  <= '0;
      end
    end
  end

endmodule

### hw/rtl/extent_path_resolver_core.sv
// Top level of the extent path resolver: register port, parser and window pipeline.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid/tready     tdata: ch; tuser: empty_path; tlast: last
//  m_*      out  tvalid/tready     tdata: extent_index, byte_base, byte_length; tuser: status
//  apb      in   psel/penable      capacity @0x00, extent size @0x08, extent count @0x10
//
// One path byte is taken every cycle while s_tready is high; the parser's multiply-add
// by ten is combinational. After its final byte a result passes the parser register,
// partial products, base sum with saturation, then the tail length in the output register.
// Reset (rst, synchronous) clears the parse state and empties the pipeline.
// Each stage holds while the stage after it is full and stalled, so a waiting result
// still lets new path bytes in until the pipeline has filled.
module extent_path_resolver_core (
  input  logic         clk,
  input  logic         rst,
  // path byte stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] ch
  input  logic         s_tuser,   // [0] empty_path
  input  logic         s_tlast,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [30:0] extent_index, [78:31] byte_base,
                                  // [126:79] byte_length, [127] zero
  output logic [1:0]   m_tuser,   // [1:0] status
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import epr_pkg::*;

  geom_t            geom;
  logic             cfg_wr;
  logic [1:0]       reg_sel;
  logic             item_valid, item_ready;
  path_item_t       item;
  logic [IDX_W-1:0] extent_index;
  logic [CAP_W-1:0] byte_base, byte_length;

  // Register port: zero wait states, one register per 8-byte slot.
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.capacity     <= CAP_W'(1);
      geom.extent_bytes <= CAP_W'(1);
      geom.extent_count <= COUNT_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CAPACITY:    geom.capacity     <= pwdata[CAP_W-1:0];
        REG_EXTENT_SIZE: geom.extent_bytes <= pwdata[CAP_W-1:0];
        REG_EXTENT_CNT:  geom.extent_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAPACITY:    prdata = {16'd0, geom.capacity};
      REG_EXTENT_SIZE: prdata = {16'd0, geom.extent_bytes};
      REG_EXTENT_CNT:  prdata = {32'd0, geom.extent_count};
      default:         prdata = '0;
    endcase
  end

  // Parse bytes; one item per finished path.
  epr_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .ch         (s_tdata),
    .empty_path (s_tuser),
    .last       (s_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Turn the index into a byte window.
  epr_window u_window (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (m_tuser),
    .extent_index (extent_index),
    .byte_base    (byte_base),
    .byte_length  (byte_length)
  );

  assign m_tdata = {1'b0, byte_length, byte_base, extent_index};

endmodule
